/* src/rpot_pkg.sv */
`default_nettype none
package rpot_pkg;

   // defaults for the top-level parameters
   localparam int MAX_VERTICES_DEF = 64;
   localparam int COORD_WIDTH_DEF  = 16;

   // fixed field widths
   localparam int EXT_WIDTH  = 15;
   localparam int MODE_WIDTH = 2;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // request kinds
   localparam logic KIND_APPEND = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   // query modes
   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_ANY    = 2'd0,
      MODE_ALL    = 2'd1,
      MODE_CENTER = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   // width of a point coordinate after adding an extent
   function automatic int point_width(input int coord_width);
      point_width = ((coord_width > EXT_WIDTH + 1) ? coord_width : EXT_WIDTH + 1) + 1;
   endfunction

endpackage
`default_nettype wire

/* src/rpot_ram.sv */
`default_nettype none
module rpot_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

/* src/rpot_front.sv */
`default_nettype none
module rpot_front #(
   parameter int COORD_WIDTH = rpot_pkg::COORD_WIDTH_DEF,
   parameter int DATA_WIDTH  = 64,
   parameter int PW          = rpot_pkg::point_width(rpot_pkg::COORD_WIDTH_DEF)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [DATA_WIDTH-1:0]            req_tdata,
   input  wire logic                             req_tuser,
   output logic                                  q_valid,
   input  wire logic                             q_ready,
   output logic                                  q_kind,
   output logic signed [PW-1:0]                  q_x,
   output logic signed [PW-1:0]                  q_y,
   output logic [rpot_pkg::EXT_WIDTH-1:0]        q_w,
   output logic [rpot_pkg::EXT_WIDTH-1:0]        q_l,
   output rpot_pkg::mode_type                    q_mode
);
   import rpot_pkg::*;

   localparam int QAW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   // request fields
   logic signed [COORD_WIDTH-1:0] f_x, f_y;
   logic [EXT_WIDTH-1:0]          f_w, f_l;
   mode_type                      f_mode;
   logic signed [PW-1:0]          base_x, base_y;

   assign f_x    = req_tdata[COORD_WIDTH-1:0];
   assign f_y    = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
   assign f_w    = req_tdata[2*COORD_WIDTH+EXT_WIDTH-1:2*COORD_WIDTH];
   assign f_l    = req_tdata[2*COORD_WIDTH+2*EXT_WIDTH-1:2*COORD_WIDTH+EXT_WIDTH];
   assign f_mode = mode_type'(req_tdata[2*COORD_WIDTH+2*EXT_WIDTH+MODE_WIDTH-1:
                                        2*COORD_WIDTH+2*EXT_WIDTH]);

   // classify: a center query collapses to one point here
   always_comb begin
      base_x = PW'(f_x);
      base_y = PW'(f_y);
      if (req_tuser == KIND_QUERY && f_mode == MODE_CENTER) begin
         base_x = PW'(f_x) + PW'(f_w >> 1);
         base_y = PW'(f_y) + PW'(f_l >> 1);
      end
   end

   // queue storage
   logic                 kind_q [QUEUE_DEPTH];
   logic signed [PW-1:0] x_q    [QUEUE_DEPTH];
   logic signed [PW-1:0] y_q    [QUEUE_DEPTH];
   logic [EXT_WIDTH-1:0] w_q    [QUEUE_DEPTH];
   logic [EXT_WIDTH-1:0] l_q    [QUEUE_DEPTH];
   mode_type             mode_q [QUEUE_DEPTH];

   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] fill_ff, fill_in;
   logic           push, pop;

   assign req_tready = (fill_ff != QCW'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != '0);
   assign pop        = q_valid && q_ready;

   assign q_kind = kind_q[rd_ptr_ff];
   assign q_x    = x_q[rd_ptr_ff];
   assign q_y    = y_q[rd_ptr_ff];
   assign q_w    = w_q[rd_ptr_ff];
   assign q_l    = l_q[rd_ptr_ff];
   assign q_mode = mode_q[rd_ptr_ff];

   // pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry write
   always_ff @(posedge clock) begin
      if (push) begin
         kind_q[wr_ptr_ff] <= req_tuser;
         x_q[wr_ptr_ff]    <= base_x;
         y_q[wr_ptr_ff]    <= base_y;
         w_q[wr_ptr_ff]    <= f_w;
         l_q[wr_ptr_ff]    <= f_l;
         mode_q[wr_ptr_ff] <= f_mode;
      end
   end

`ifndef NO_ASSERTIONS
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QCW'(QUEUE_DEPTH)) else $error("queue overfilled");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || fill_ff == QCW'(QUEUE_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with fill");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      pop |=> rd_ptr_ff == $past(rd_ptr_ff) + 1'b1) else $error("pop lost");
`endif

endmodule
`default_nettype wire

/* src/rpot_back.sv */
`default_nettype none
module rpot_back #(
   parameter int MAX_VERTICES = rpot_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = rpot_pkg::COORD_WIDTH_DEF,
   parameter int PW           = rpot_pkg::point_width(rpot_pkg::COORD_WIDTH_DEF)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_valid,
   output logic                              q_ready,
   input  wire logic                         q_kind,
   input  wire logic signed [PW-1:0]         q_x,
   input  wire logic signed [PW-1:0]         q_y,
   input  wire logic [rpot_pkg::EXT_WIDTH-1:0] q_w,
   input  wire logic [rpot_pkg::EXT_WIDTH-1:0] q_l,
   input  wire rpot_pkg::mode_type           q_mode,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_inside
);
   import rpot_pkg::*;

   localparam int CW   = COORD_WIDTH;
   localparam int AW   = $clog2(MAX_VERTICES);
   localparam int NW   = $clog2(MAX_VERTICES + 1);
   localparam int PRW  = CW + PW + 3;
   localparam int MW   = PW + CW + 4;
   localparam int CMPW = (PRW > MW) ? PRW : MW;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type            st_ff, st_in;
   logic [NW-1:0]        cnt_ff, cnt_in;
   logic [NW-1:0]        idx_ff, idx_in;
   logic [1:0]           corner_ff, corner_in;
   logic                 par_ff, par_in;
   logic signed [PW-1:0] bx_ff, by_ff;
   logic [EXT_WIDTH-1:0] w_ff, l_ff;
   mode_type             mode_ff;
   logic                 load;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_res_ff, rsp_res_in;

   // vertex memory
   logic                   ram_we;
   logic [AW-1:0]          ram_raddr;
   logic [2*CW-1:0]        ram_rdata;
   logic                   prime_rd, edge_rd;
   logic                   prime_pend_ff, edge_pend_ff;

   rpot_ram #(.WIDTH(2 * CW), .DEPTH(MAX_VERTICES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data ({q_y[CW-1:0], q_x[CW-1:0]}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // current test point
   logic signed [PW-1:0] px, py;
   assign px = bx_ff + (corner_ff[0] ? PW'(w_ff) : PW'(0));
   assign py = by_ff + (corner_ff[1] ? PW'(l_ff) : PW'(0));

   // stage 1: edge geometry from the fetched vertex and the previous one
   logic signed [CW-1:0] xi, yi;
   logic signed [CW-1:0] prev_x_ff, prev_y_ff;
   logic signed [CW:0]   a1, d1;
   logic signed [PW:0]   b1, t1;
   logic                 strad1, pneg1;
   assign xi     = ram_rdata[CW-1:0];
   assign yi     = ram_rdata[2*CW-1:CW];
   assign a1     = (CW+1)'(prev_x_ff) - (CW+1)'(xi);
   assign d1     = (CW+1)'(prev_y_ff) - (CW+1)'(yi);
   assign b1     = (PW+1)'(py) - (PW+1)'(yi);
   assign t1     = (PW+1)'(px) - (PW+1)'(xi);
   assign strad1 = ((PW+1)'(yi) > (PW+1)'(py)) != ((PW+1)'(prev_y_ff) > (PW+1)'(py));
   assign pneg1  = (a1 != '0) && (b1 != '0) && ((a1[CW] ^ b1[PW]) ^ d1[CW]);

   logic                 s2_v_ff;
   logic                 s2_pneg_ff, s2_dneg_ff;
   logic signed [CW:0]   s2_a_ff;
   logic signed [PW:0]   s2_b_ff;
   logic signed [CW+1:0] s2_dm_ff;
   logic signed [PW+1:0] s2_t_ff;

   always_ff @(posedge clock) begin
      if (prime_pend_ff || edge_pend_ff) begin
         prev_x_ff <= xi;
         prev_y_ff <= yi;
      end
      s2_pneg_ff <= pneg1;
      s2_dneg_ff <= d1[CW];
      s2_a_ff    <= a1;
      s2_b_ff    <= b1;
      s2_dm_ff   <= d1[CW] ? -(CW+2)'(d1) : (CW+2)'(d1);
      // t < trunc(r): strict for negative r, (t+1) <= r otherwise
      s2_t_ff    <= pneg1 ? (PW+2)'(t1) : (PW+2)'(t1) + (PW+2)'(1);
   end

   // stage 2: the two products
   logic signed [PRW-1:0] ab2;
   logic signed [MW-1:0]  m2;
   assign ab2 = PRW'(s2_a_ff) * PRW'(s2_b_ff);
   assign m2  = MW'(s2_t_ff) * MW'(s2_dm_ff);

   logic                   s3_v_ff, s3_pneg_ff;
   logic signed [CMPW-1:0] s3_p_ff, s3_m_ff;

   always_ff @(posedge clock) begin
      s3_pneg_ff <= s2_pneg_ff;
      s3_p_ff    <= s2_dneg_ff ? -CMPW'(ab2) : CMPW'(ab2);
      s3_m_ff    <= CMPW'(m2);
   end

   // stage 3: crossing test
   logic cross3;
   assign cross3 = s3_v_ff && (s3_pneg_ff ? (s3_m_ff < s3_p_ff) : (s3_m_ff <= s3_p_ff));

   logic pipe_empty;
   assign pipe_empty = !prime_pend_ff && !edge_pend_ff && !s2_v_ff && !s3_v_ff;

   // control sequencer
   always_comb begin
      st_in        = st_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      corner_in    = corner_ff;
      par_in       = par_ff ^ cross3;
      load         = 1'b0;
      q_ready      = 1'b0;
      ram_we       = 1'b0;
      ram_raddr    = idx_ff[AW-1:0];
      prime_rd     = 1'b0;
      edge_rd      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_res_in   = rsp_res_ff;
      case (st_ff)
         ST_IDLE: begin
            if (q_valid && q_kind == KIND_APPEND) begin
               q_ready = 1'b1;
               if (cnt_ff < NW'(MAX_VERTICES)) begin
                  ram_we = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
            end else if (q_valid && !rsp_valid_ff) begin
               q_ready = 1'b1;
               if (q_mode == MODE_NONE || cnt_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_res_in   = 1'b0;
               end else begin
                  load      = 1'b1;
                  corner_in = 2'd0;
                  par_in    = 1'b0;
                  idx_in    = '0;
                  ram_raddr = AW'(cnt_ff - 1'b1);
                  prime_rd  = 1'b1;
                  st_in     = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            edge_rd = 1'b1;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == cnt_ff - 1'b1) begin
               st_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               if ((mode_ff == MODE_ANY && par_ff) || (mode_ff == MODE_ALL && !par_ff) ||
                   mode_ff == MODE_CENTER || corner_ff == 2'd3) begin
                  rsp_valid_in = 1'b1;
                  rsp_res_in   = par_ff;
                  st_in        = ST_IDLE;
               end else begin
                  corner_in = corner_ff + 1'b1;
                  par_in    = 1'b0;
                  idx_in    = '0;
                  ram_raddr = AW'(cnt_ff - 1'b1);
                  prime_rd  = 1'b1;
                  st_in     = ST_RUN;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         prime_pend_ff <= 1'b0;
         edge_pend_ff  <= 1'b0;
         s2_v_ff       <= 1'b0;
         s3_v_ff       <= 1'b0;
      end else begin
         st_ff         <= st_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         prime_pend_ff <= prime_rd;
         edge_pend_ff  <= edge_rd;
         s2_v_ff       <= edge_pend_ff && strad1;
         s3_v_ff       <= s2_v_ff;
      end
   end

   // datapath state
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      corner_ff  <= corner_in;
      par_ff     <= par_in;
      rsp_res_ff <= rsp_res_in;
      if (load) begin
         bx_ff   <= q_x;
         by_ff   <= q_y;
         w_ff    <= q_w;
         l_ff    <= q_l;
         mode_ff <= q_mode;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_inside = rsp_res_ff;

`ifndef NO_ASSERTIONS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(st_ff)) else $error("sequencer state not one-hot");
   a_no_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> !rsp_valid_ff) else $error("response pending during walk");
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= NW'(MAX_VERTICES)) else $error("vertex count over capacity");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_RUN) |-> idx_ff < cnt_ff) else $error("edge index past count");
`endif

endmodule
`default_nettype wire

/* src/rect_polygon_overlap_test.sv */
// Append request: taken by the walker in its idle state once it leaves the queue; no response.
// Query request: per tested point, a prime read of the closing vertex, then one vertex read
// per cycle over the N stored vertices, then a drain of the pipeline;
// up to four points per query in the walker.
// A four-entry queue decouples intake and registers each request; responses sit in a register.
// Reset (synchronous, active high) empties the queue and the vertex count.
`default_nettype none
module rect_polygon_overlap_test #(
   parameter int MAX_VERTICES = rpot_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = rpot_pkg::COORD_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // point_x, point_y, rect_width, rect_length, test_mode (low bit up)
   input  wire logic [((2*COORD_WIDTH+2*rpot_pkg::EXT_WIDTH+rpot_pkg::MODE_WIDTH+7)/8)*8-1:0]
                     req_tdata,
   // kind
   input  wire logic req_tuser,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // inside_res
   output logic [7:0] rsp_tdata
);
   import rpot_pkg::*;

   localparam int PW = point_width(COORD_WIDTH);
   localparam int DW = ((2*COORD_WIDTH+2*EXT_WIDTH+MODE_WIDTH+7)/8)*8;

   logic                 q_valid, q_ready, q_kind;
   logic signed [PW-1:0] q_x, q_y;
   logic [EXT_WIDTH-1:0] q_w, q_l;
   mode_type             q_mode;
   logic                 inside_res;

   rpot_front #(.COORD_WIDTH(COORD_WIDTH), .DATA_WIDTH(DW), .PW(PW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_kind     (q_kind),
      .q_x        (q_x),
      .q_y        (q_y),
      .q_w        (q_w),
      .q_l        (q_l),
      .q_mode     (q_mode)
   );

   rpot_back #(.MAX_VERTICES(MAX_VERTICES), .COORD_WIDTH(COORD_WIDTH), .PW(PW)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_kind     (q_kind),
      .q_x        (q_x),
      .q_y        (q_y),
      .q_w        (q_w),
      .q_l        (q_l),
      .q_mode     (q_mode),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_inside (inside_res)
   );

   assign rsp_tdata = {7'b0, inside_res};

endmodule
`default_nettype wire

/* tb/tb_rect_polygon_overlap_test.sv */
`default_nettype none
module tb_rect_polygon_overlap_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rpot_pkg::*;

   localparam int NVERT    = 64;
   localparam int CW       = 16;
   localparam int REQ_BITS = ((2*CW+2*EXT_WIDTH+MODE_WIDTH+7)/8)*8;

   // one request as seen at the input
   typedef struct packed {
      logic                  kind;
      logic signed [CW-1:0]  px;
      logic signed [CW-1:0]  py;
      logic [EXT_WIDTH-1:0]  rw;
      logic [EXT_WIDTH-1:0]  rl;
      mode_type              mode;
   } poly_req_type;

   // scoreboard: polygon model plus queue of expected inside flags
   class overlap_scoreboard;
      longint vx[NVERT];
      longint vy[NVERT];
      int     nvert;
      bit     inside_q[$];
      int     errors;

      function new();
         nvert  = 0;
         errors = 0;
      endfunction

      // even-odd crossing test, truncating division
      function bit point_in(longint x, longint y);
         bit     flag;
         int     j;
         longint a, b, d, q;
         flag = 0;
         if (nvert == 0) return 0;
         j = nvert - 1;
         for (int i = 0; i < nvert; i++) begin
            if ((vy[i] > y) != (vy[j] > y)) begin
               a = vx[j] - vx[i];
               b = y - vy[i];
               d = vy[j] - vy[i];
               q = (a * b) / d;
               if (x < q + vx[i]) flag = !flag;
            end
            j = i;
         end
         return flag;
      endfunction

      function void note_request(poly_req_type r);
         longint x, y, w, l;
         bit     res;
         x = r.px; y = r.py; w = r.rw; l = r.rl;
         if (r.kind == KIND_APPEND) begin
            if (nvert < NVERT) begin
               vx[nvert] = x; vy[nvert] = y; nvert++;
            end
            return;
         end
         res = 0;
         case (r.mode)
            MODE_ANY: begin
               for (int c = 0; c < 4 && !res; c++)
                  res = point_in(x + (c & 1) * w, y + (c >> 1) * l);
            end
            MODE_ALL: begin
               res = 1;
               for (int c = 0; c < 4 && res; c++)
                  res = point_in(x + (c & 1) * w, y + (c >> 1) * l);
            end
            MODE_CENTER: res = point_in(x + w / 2, y + l / 2);
            default: res = 0;
         endcase
         inside_q.push_back(res);
      endfunction

      function void check_response(logic [7:0] data);
         bit exp_res;
         if (inside_q.size() == 0) begin
            $error("unexpected response inside_res=%0d", data[0]);
            errors++;
            return;
         end
         exp_res = inside_q.pop_front();
         if (data[0] !== exp_res) begin
            $error("inside_res mismatch: expected %0d actual %0d", exp_res, data[0]);
            errors++;
         end
      endfunction
   endclass

   logic                clock = 0;
   logic                reset = 1;
   logic                req_tvalid = 0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic                req_tuser = 0;
   logic                rsp_tvalid;
   logic                rsp_tready = 0;
   logic [7:0]          rsp_tdata;

   overlap_scoreboard sb;
   bit  calm_phase  = 0;   // no idling on either side
   bit  hold_rsp    = 0;   // long receiver hold-off
   bit  stim_done   = 0;

   rect_polygon_overlap_test u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #2 clock = ~clock;

   // send one request, with random idle first; valid stays up between back-to-back requests
   task automatic send_request(poly_req_type r);
      if (!calm_phase && $urandom_range(99) < 36) begin
         req_tvalid <= 0;
         do @(posedge clock); while ($urandom_range(99) < 36);
      end
      req_tvalid <= 1;
      req_tuser  <= r.kind;
      req_tdata  <= {{(REQ_BITS-2*CW-2*EXT_WIDTH-MODE_WIDTH){1'b0}},
                     r.mode, r.rl, r.rw, r.py, r.px};
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
   endtask

   function automatic poly_req_type make_append(int x, int y);
      poly_req_type r;
      r = '0;
      r.kind = KIND_APPEND;
      r.px = CW'(x); r.py = CW'(y);
      r.rw = EXT_WIDTH'($urandom); r.rl = EXT_WIDTH'($urandom);
      r.mode = mode_type'($urandom_range(3));
      return r;
   endfunction

   function automatic poly_req_type make_query(int x, int y, int w, int l, mode_type m);
      poly_req_type r;
      r.kind = KIND_QUERY;
      r.px = CW'(x); r.py = CW'(y);
      r.rw = EXT_WIDTH'(w); r.rl = EXT_WIDTH'(l);
      r.mode = m;
      return r;
   endfunction

   // random query, mostly near the polygon scale
   function automatic poly_req_type rand_query(int span);
      if ($urandom_range(9) == 0)
         return make_query($urandom, $urandom, $urandom, $urandom,
                           mode_type'($urandom_range(3)));
      return make_query($signed($urandom_range(2*span)) - span,
                        $signed($urandom_range(2*span)) - span,
                        $urandom_range(span), $urandom_range(span),
                        mode_type'($urandom_range(3)));
   endfunction

   // response side
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         rsp_tready <= !hold_rsp && (calm_phase || $urandom_range(99) >= 36);
      end
   end

   // long receiver hold-off, counted in cycles
   initial begin
      wait (stim_done == 0 && sb != null);
      repeat (3000) @(posedge clock);
      hold_rsp = 1;
      repeat (2000) @(posedge clock);
      hold_rsp = 0;
   end

   initial begin
      int           span;
      int           nv;
      int           wait_cnt;
      poly_req_type r;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty polygon, then a square, extremes and every mode
      send_request(make_query(0, 0, 10, 10, MODE_ANY));
      send_request(make_query(-32768, 32767, 32767, 32767, MODE_ALL));
      send_request(make_append(-100, -100));
      send_request(make_query(-100, -100, 0, 0, MODE_CENTER));
      send_request(make_append(-100, 100));
      send_request(make_query(-200, 0, 400, 0, MODE_ANY));
      send_request(make_append(100, 100));
      send_request(make_append(100, -100));
      for (int m = 0; m < 4; m++) begin
         send_request(make_query(-50, -50, 100, 100, mode_type'(m)));
         send_request(make_query(-150, -150, 300, 300, mode_type'(m)));
      end
      send_request(make_query(32767, -32768, 32767, 32767, MODE_ANY));
      send_request(make_query(-32768, -32768, 32767, 32767, MODE_CENTER));
      send_request(make_query(-1, -1, 1, 1, MODE_ALL));

      // random phase: the store grows to full and stays there
      for (int n = 0; n < 1500; n++) begin
         calm_phase = (n >= 600 && n < 800);
         if (n % 60 == 0 || $urandom_range(99) < 8) begin
            // append a burst of vertices; full-range or large coordinates
            nv = $urandom_range(1, 6);
            for (int k = 0; k < nv; k++) begin
               if ($urandom_range(3) == 0)
                  r = make_append($urandom, $urandom);
               else
                  r = make_append($signed($urandom_range(2000)) - 1000,
                                  $signed($urandom_range(2000)) - 1000);
               send_request(r);
            end
         end
         span = ($urandom_range(3) == 0) ? 30000 : 1200;
         send_request(rand_query(span));
      end
      req_tvalid <= 0;
      calm_phase = 0;
      stim_done = 1;

      // drain
      wait_cnt = 0;
      while (sb.inside_q.size() != 0 && wait_cnt < 200000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (2000) @(posedge clock);
      if (sb.errors == 0 && sb.inside_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire

/* sim.f */
src/rpot_pkg.sv
src/rpot_ram.sv
src/rpot_front.sv
src/rpot_back.sv
src/rect_polygon_overlap_test.sv
tb/tb_rect_polygon_overlap_test.sv
